### hdl/utf8d_pkg.sv
// Shared types, constants and helpers of the UTF-8 byte stream decoder.
package utf8d_pkg;

  localparam int unsigned CpWidth    = 21;
  localparam int unsigned RqDepthDef = 4;

  localparam logic [CpWidth-1:0] Replacement = 21'h00FFFD;

  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic               replaced;
    logic               last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0]       count;
    result_t [1:0]    res;
  } dec_t;

  function automatic result_t mk_result(logic [CpWidth-1:0] cp, logic repl);
    result_t r;
    r.code_point  = cp;
    r.replaced    = repl;
    r.last_of_run = 1'b0;
    return r;
  endfunction

endpackage

### hdl/utf8d_decode.sv
// Decoder state and the per-byte decode of up to two results.
module utf8d_decode import utf8d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  output dec_t       dec_o
);

  logic [CpWidth-1:0] pc_q, pc_d;
  logic [1:0]         bp_q, bp_d;
  logic [CpWidth-1:0] acc;
  logic [1:0]         n;
  logic [1:0]         nm1;
  result_t [1:0]      res;

  always_comb begin
    pc_d = pc_q;
    bp_d = bp_q;
    n    = 2'd0;
    res  = '0;
    nm1  = 2'd0;
    acc  = {pc_q[CpWidth-7:0], text_byte_i[5:0]};
    case (text_byte_i) inside
      [8'h00:8'h7F]: begin
        if (bp_q != 2'd0) begin
          res[n[0]] = mk_result(Replacement, 1'b1);
          n = n + 2'd1;
        end
        bp_d = 2'd0;
        res[n[0]] = mk_result({{(CpWidth-8){1'b0}}, text_byte_i}, 1'b0);
        n = n + 2'd1;
      end
      [8'h80:8'hBF]: begin
        if (bp_q != 2'd0) begin
          pc_d = acc;
          bp_d = bp_q - 2'd1;
          if (bp_d == 2'd0) begin
            res[n[0]] = mk_result(acc, 1'b0);
            n = n + 2'd1;
          end
        end else begin
          res[n[0]] = mk_result(Replacement, 1'b1);
          n = n + 2'd1;
        end
      end
      [8'hC0:8'hDF]: begin
        bp_d = 2'd1;
        pc_d = {{(CpWidth-5){1'b0}}, text_byte_i[4:0]};
      end
      [8'hE0:8'hEF]: begin
        bp_d = 2'd2;
        pc_d = {{(CpWidth-4){1'b0}}, text_byte_i[3:0]};
      end
      [8'hF0:8'hF7]: begin
        bp_d = 2'd3;
        pc_d = {{(CpWidth-3){1'b0}}, text_byte_i[2:0]};
      end
      default: begin
        res[n[0]] = mk_result(Replacement, 1'b1);
        n = n + 2'd1;
        bp_d = 2'd0;
      end
    endcase
    if (end_of_text_i) begin
      if (bp_d != 2'd0) begin
        res[n[0]] = mk_result(Replacement, 1'b1);
        n = n + 2'd1;
      end
      pc_d = '0;
      bp_d = 2'd0;
    end
    if (n != 2'd0) begin
      nm1 = n - 2'd1;
      res[nm1[0]].last_of_run = 1'b1;
    end
  end

  assign dec_o.count = n;
  assign dec_o.res   = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
      bp_q <= 2'd0;
    end else if (accept_i) begin
      pc_q <= pc_d;
      bp_q <= bp_d;
    end
  end

  a_eot_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && end_of_text_i) |=> (bp_q == 2'd0 && pc_q == '0))
    else $error("state not cleared after end of text");

  a_lead_pends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && !end_of_text_i && text_byte_i >= 8'hC0 && text_byte_i <= 8'hF7)
    |=> (bp_q != 2'd0))
    else $error("lead byte did not start a sequence");

  a_two_has_repl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dec_o.count == 2'd2) |-> (dec_o.res[0].replaced || dec_o.res[1].replaced))
    else $error("two results without a replacement");

endmodule

### hdl/utf8d_rq.sv
// Result queue that takes up to two results per cycle and delivers one on each pop.
module utf8d_rq import utf8d_pkg::*; #(
  parameter int unsigned Depth = RqDepthDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  dec_t    push_i,
  input  logic    pop_i,
  output logic    can_take_o,
  output logic    valid_o,
  output result_t head_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] TakeMax = CntW'(Depth - 2);

  result_t        mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, wr1, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr1 = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    case (push_i.count)
      2'd1:    wr_d = wr1;
      2'd2:    wr_d = (wr1 == LastPtr) ? '0 : wr1 + 1'b1;
      default: wr_d = wr_q;
    endcase
    rd_d  = pop_i ? ((rd_q == LastPtr) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + CntW'(push_i.count) - CntW'(pop_i);
  end

  assign can_take_o = (cnt_q <= TakeMax);
  assign valid_o    = (cnt_q != '0);
  assign head_o     = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.res[0];
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr1] <= push_i.res[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("result queue overflow");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 2'd0) |-> (cnt_q <= TakeMax))
    else $error("push into a queue without room for two results");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && push_i.count == 2'd0) |=> (cnt_q == $past(cnt_q) - 1'b1))
    else $error("queue count did not drop on a pop");

endmodule

### hdl/utf8_byte_stream_decoder_top.sv
// Top level of the UTF-8 byte stream decoder.
// Each result is registered in the result queue before it appears on the output.
// One byte is accepted per cycle while the input does not stall; a byte that gives two results delivers them in turn.
// The input stalls while the result queue has fewer than two free entries.
// Reset clears the accumulator, the pending count and the result queue.
module utf8_byte_stream_decoder_top import utf8d_pkg::*; #(
  parameter int unsigned RqDepth = RqDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          text_byte_i,
  input  logic                end_of_text_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CpWidth-1:0]  code_point_o,
  output logic                replaced_o,
  output logic                last_of_run_o
);

  logic    accept;
  logic    can_take;
  logic    pop;
  dec_t    dec;
  dec_t    push;
  result_t head;

  assign in_stall_o = !can_take;
  assign accept     = in_valid_i && can_take;
  assign pop        = out_valid_o && !out_stall_i;

  utf8d_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .dec_o         (dec)
  );

  always_comb begin
    push = dec;
    if (!accept) begin
      push.count = 2'd0;
    end
  end

  utf8d_rq #(
    .Depth (RqDepth)
  ) u_rq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .pop_i      (pop),
    .can_take_o (can_take),
    .valid_o    (out_valid_o),
    .head_o     (head)
  );

  assign code_point_o  = head.code_point;
  assign replaced_o    = head.replaced;
  assign last_of_run_o = head.last_of_run;

endmodule
